FILE: hw/rtl/dphh_pkg.sv
// Shared types and constants for the lateral drive controller with heading hold.
package dphh_pkg;

  localparam int GAIN_FRAC_BITS = 8;

  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAX_SPEED,
    REG_POS_TARGET,
    REG_HDG_TARGET,
    REG_DRIVE_KP,
    REG_DRIVE_KI,
    REG_DRIVE_KD,
    REG_HEADING_KP,
    REG_HEADING_KD
  } reg_idx_t;

  typedef struct packed {
    logic        [6:0]  max_speed;
    logic signed [23:0] position_target;
    logic signed [15:0] heading_target;
    logic        [15:0] drive_kp;
    logic        [15:0] drive_ki;
    logic        [15:0] drive_kd;
    logic        [15:0] heading_kp;
    logic        [15:0] heading_kd;
  } cfg_t;

  localparam logic [6:0]  MAX_SPEED_RST  = 7'd100;
  localparam logic [15:0] DRIVE_KP_RST   = 16'd38;
  localparam logic [15:0] DRIVE_KI_RST   = 16'd0;
  localparam logic [15:0] DRIVE_KD_RST   = 16'd294;
  localparam logic [15:0] HEADING_KP_RST = 16'd23;
  localparam logic [15:0] HEADING_KD_RST = 16'd4;

  localparam logic signed [25:0] INTEG_LIMIT = 26'sd4000;
  localparam logic signed [24:0] NEAR_BAND   = 25'sd20;
  localparam logic        [2:0]  NEAR_MAX    = 3'd7;
  localparam logic        [2:0]  SETTLE_CNT  = 3'd4;
  localparam logic signed [36:0] DRIVE_LIMIT = 37'sd100;

endpackage

FILE: hw/rtl/dphh_regs.sv
// Configuration register file: index decode, reset values.
module dphh_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dphh_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [dphh_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dphh_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed       <= dphh_pkg::MAX_SPEED_RST;
      cfg.position_target <= '0;
      cfg.heading_target  <= '0;
      cfg.drive_kp        <= dphh_pkg::DRIVE_KP_RST;
      cfg.drive_ki        <= dphh_pkg::DRIVE_KI_RST;
      cfg.drive_kd        <= dphh_pkg::DRIVE_KD_RST;
      cfg.heading_kp      <= dphh_pkg::HEADING_KP_RST;
      cfg.heading_kd      <= dphh_pkg::HEADING_KD_RST;
    end else if (cfg_we) begin
      case (dphh_pkg::reg_idx_t'(cfg_index))
        dphh_pkg::REG_MAX_SPEED:  cfg.max_speed       <= cfg_data[6:0];
        dphh_pkg::REG_POS_TARGET: cfg.position_target <= cfg_data[23:0];
        dphh_pkg::REG_HDG_TARGET: cfg.heading_target  <= cfg_data[15:0];
        dphh_pkg::REG_DRIVE_KP:   cfg.drive_kp        <= cfg_data[15:0];
        dphh_pkg::REG_DRIVE_KI:   cfg.drive_ki        <= cfg_data[15:0];
        dphh_pkg::REG_DRIVE_KD:   cfg.drive_kd        <= cfg_data[15:0];
        dphh_pkg::REG_HEADING_KP: cfg.heading_kp      <= cfg_data[15:0];
        dphh_pkg::REG_HEADING_KD: cfg.heading_kd      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/drive_pid_with_heading_hold_top.sv
// Top level: lateral position PID with heading PD hold, differential drive output.
// Takes one input word per clock and gives one result word per clock while the
// output is not stalled. Each word passes through the input register, error and
// state update, gain multiplies, product sum with fraction drop, then limiting
// and saturation into the output register. The controller state (last errors,
// integral, near counter, settled flag) is updated in the error stage, so each
// word sees the state left by the one before it. Words with lateral_active low
// produce no result word but clear the settled flag in order. Output stalls back
// up through the stages; the input stays ready while any stage has room.
module drive_pid_with_heading_hold_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [39:0]                     s_tdata,   // position[23:0], heading[39:24]
  input  logic                            s_tuser,   // lateral_active
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // right_drive[7:0], left_drive[15:8],
                                                     // settled[16], zero pad[23:17]
  input  logic                            cfg_we,
  input  logic [dphh_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [dphh_pkg::CFG_DATA_W-1:0] cfg_data
);

  dphh_pkg::cfg_t cfg;

  dphh_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage enables, back to front
  logic en_in, en_a, en_b, en_c, en_out;
  logic v_in, v_a, v_b, v_c;

  assign en_out   = !m_tvalid || m_tready;
  assign en_c     = !v_c || en_out;
  assign en_b     = !v_b || en_c;
  assign en_a     = !v_a || en_b;
  assign en_in    = !v_in || en_a;
  assign s_tready = en_in;

  // input register
  logic               in_lat;
  logic signed [23:0] in_pos;
  logic signed [15:0] in_hdg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (en_in) begin
      v_in <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in) begin
      in_lat <= s_tuser;
      in_pos <= s_tdata[23:0];
      in_hdg <= s_tdata[39:24];
    end
  end

  // controller state
  logic signed [24:0] last_pos_error;
  logic signed [13:0] pos_integral;
  logic signed [16:0] last_heading_error;
  logic        [2:0]  near_count;
  logic               settled_flag;

  logic signed [24:0] err;
  logic signed [25:0] integ_sum;
  logic signed [13:0] integ_next;
  logic signed [25:0] delta;
  logic signed [16:0] herr;
  logic signed [17:0] hdelta;
  logic               near;
  logic        [2:0]  near_count_next;
  logic               settled_next;

  always_comb begin
    err       = 25'(cfg.position_target) - 25'(in_pos);
    integ_sum = 26'(pos_integral) + 26'(err);
    if (integ_sum > dphh_pkg::INTEG_LIMIT) begin
      integ_next = 14'(dphh_pkg::INTEG_LIMIT);
    end else if (integ_sum < -dphh_pkg::INTEG_LIMIT) begin
      integ_next = 14'(-dphh_pkg::INTEG_LIMIT);
    end else if (err == '0) begin
      integ_next = '0;
    end else begin
      integ_next = integ_sum[13:0];
    end
    delta  = 26'(err) - 26'(last_pos_error);
    herr   = 17'(cfg.heading_target) - 17'(in_hdg);
    hdelta = 18'(herr) - 18'(last_heading_error);
    near   = (err >= -dphh_pkg::NEAR_BAND) && (err <= dphh_pkg::NEAR_BAND);
    near_count_next = near_count;
    settled_next    = settled_flag;
    if (!in_lat) begin
      settled_next = 1'b0;
    end else if (near) begin
      if (near_count != dphh_pkg::NEAR_MAX) begin
        near_count_next = near_count + 3'd1;
      end
      if (near_count_next > dphh_pkg::SETTLE_CNT) begin
        settled_next = 1'b1;
      end
    end
  end

  logic step;
  assign step = en_a && v_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pos_error     <= '0;
      pos_integral       <= '0;
      last_heading_error <= '0;
      near_count         <= '0;
      settled_flag       <= 1'b0;
    end else if (step) begin
      settled_flag <= settled_next;
      if (in_lat) begin
        last_pos_error     <= err;
        pos_integral       <= integ_next;
        last_heading_error <= herr;
        near_count         <= near_count_next;
      end
    end
  end

  // error stage register
  logic signed [24:0] a_err;
  logic signed [13:0] a_integ;
  logic signed [25:0] a_delta;
  logic signed [16:0] a_herr;
  logic signed [17:0] a_hdelta;
  logic               a_settled;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en_a) begin
      v_a <= v_in && in_lat;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_err     <= err;
      a_integ   <= integ_next;
      a_delta   <= delta;
      a_herr    <= herr;
      a_hdelta  <= hdelta;
      a_settled <= settled_next;
    end
  end

  // multiply stage; gains are unsigned, widened by a zero sign bit
  logic signed [16:0] g_dkp, g_dki, g_dkd, g_hkp, g_hkd;
  assign g_dkp = $signed({1'b0, cfg.drive_kp});
  assign g_dki = $signed({1'b0, cfg.drive_ki});
  assign g_dkd = $signed({1'b0, cfg.drive_kd});
  assign g_hkp = $signed({1'b0, cfg.heading_kp});
  assign g_hkd = $signed({1'b0, cfg.heading_kd});

  logic signed [41:0] b_pp;
  logic signed [30:0] b_pi;
  logic signed [42:0] b_pd;
  logic signed [33:0] b_hp;
  logic signed [34:0] b_hd;
  logic               b_settled;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en_b) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_pp      <= a_err * g_dkp;
      b_pi      <= a_integ * g_dki;
      b_pd      <= a_delta * g_dkd;
      b_hp      <= a_herr * g_hkp;
      b_hd      <= a_hdelta * g_hkd;
      b_settled <= a_settled;
    end
  end

  // sum stage: exact sum, then drop fraction bits toward zero
  localparam logic signed [44:0] SPD_ROUND = 45'((1 << dphh_pkg::GAIN_FRAC_BITS) - 1);
  localparam logic signed [35:0] HDG_ROUND = 36'((1 << dphh_pkg::GAIN_FRAC_BITS) - 1);

  logic signed [44:0] spd_sum, spd_adj;
  logic signed [35:0] hdg_sum, hdg_adj;

  always_comb begin
    spd_sum = 45'(b_pp) + 45'(b_pi) + 45'(b_pd);
    spd_adj = spd_sum[44] ? spd_sum + SPD_ROUND : spd_sum;
    hdg_sum = 36'(b_hp) + 36'(b_hd);
    hdg_adj = hdg_sum[35] ? hdg_sum + HDG_ROUND : hdg_sum;
  end

  logic signed [44:0] c_speed;
  logic signed [35:0] c_sr;
  logic               c_settled;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (en_c) begin
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_speed   <= spd_adj >>> dphh_pkg::GAIN_FRAC_BITS;
      c_sr      <= hdg_adj >>> dphh_pkg::GAIN_FRAC_BITS;
      c_settled <= b_settled;
    end
  end

  // limit stage: speed clamp, heading mix, saturate to +/-100
  logic signed [44:0] lim, spd_1, spd_2;
  logic signed [7:0]  spd;
  logic signed [36:0] right_raw, left_raw;
  logic signed [7:0]  right_sat, left_sat;

  always_comb begin
    lim   = $signed({38'd0, cfg.max_speed});
    spd_1 = (c_speed >= lim) ? lim : c_speed;
    spd_2 = (spd_1 <= -lim) ? -lim : spd_1;
    spd   = spd_2[7:0];
    right_raw = 37'(spd) - 37'(c_sr);
    left_raw  = 37'(spd) + 37'(c_sr);
    if (right_raw > dphh_pkg::DRIVE_LIMIT) begin
      right_sat = 8'(dphh_pkg::DRIVE_LIMIT);
    end else if (right_raw < -dphh_pkg::DRIVE_LIMIT) begin
      right_sat = 8'(-dphh_pkg::DRIVE_LIMIT);
    end else begin
      right_sat = right_raw[7:0];
    end
    if (left_raw > dphh_pkg::DRIVE_LIMIT) begin
      left_sat = 8'(dphh_pkg::DRIVE_LIMIT);
    end else if (left_raw < -dphh_pkg::DRIVE_LIMIT) begin
      left_sat = 8'(-dphh_pkg::DRIVE_LIMIT);
    end else begin
      left_sat = left_raw[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tdata <= {7'd0, c_settled, left_sat, right_sat};
    end
  end

  // checks
  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    (26'(pos_integral) <= dphh_pkg::INTEG_LIMIT) &&
    (26'(pos_integral) >= -dphh_pkg::INTEG_LIMIT))
    else $error("position integral outside clamp");

  a_settled_count: assert property (@(posedge clk) disable iff (rst)
    settled_flag |-> (near_count > dphh_pkg::SETTLE_CNT))
    else $error("settled without enough near ticks");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[7:0]) <= 8'sd100) && ($signed(m_tdata[7:0]) >= -8'sd100) &&
                 ($signed(m_tdata[15:8]) <= 8'sd100) && ($signed(m_tdata[15:8]) >= -8'sd100))
    else $error("drive command outside saturation range");

endmodule
